// ===== hdl/ccd_pkg.sv =====
// Shared types and constants for the cylinder collision displacement block.
`timescale 1ns / 1ps

package ccd_pkg;

    localparam int COORD_W     = 16;
    localparam int RADIUS_W    = 15;
    localparam int SQ_W        = 32;
    localparam int ROOT_W      = 16;
    localparam int SQRT_CELLS  = SQ_W / 2;
    localparam int FRAC_BITS_D = 12;
    localparam logic [RADIUS_W-1:0] DIST_MAX = '1;

    // Per-item context carried along the whole pipe
    typedef struct packed {
        logic                       yrej;
        logic signed [COORD_W-1:0]  rsum;
        logic signed [COORD_W-1:0]  dx;
        logic signed [COORD_W-1:0]  dz;
    } ctx_t;

    // Square root cell data
    typedef struct packed {
        ctx_t               ctx;
        logic [SQ_W-1:0]    sq;
        logic [17:0]        rem;
        logic [ROOT_W-1:0]  root;
    } sqrt_t;

    // Distance/depth results carried through the divider
    typedef struct packed {
        ctx_t                       ctx;
        logic [RADIUS_W-1:0]        dlen;
        logic signed [COORD_W-1:0]  depth;
        logic                       ov;
        logic                       go;
    } res_t;

endpackage

// ===== hdl/cylinder_collision_displacement.sv =====
// Top level: pipelined vertical cylinder collision test with push-out vector.
//
//   channel  | direction | payload
//   s_*      | in        | two cylinders: origin, radius, height
//   m_*      | out       | overlap, distance, depth, deltas, push vector
//
// One pair per cycle while no result waits unread; 16 square root cells, one divider
// cell per quotient bit, plus five register stages.
// The whole pipe advances together; it holds when a result waits unread,
// and s_ready is low exactly then. Reset (aresetn low, synchronous) empties it.
`timescale 1ns / 1ps

module cylinder_collision_displacement #(
    parameter int FRAC_BITS = ccd_pkg::FRAC_BITS_D
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic signed [15:0]  s_a_x,
    input  logic signed [15:0]  s_a_y,
    input  logic signed [15:0]  s_a_z,
    input  logic [14:0]         s_a_radius,
    input  logic [14:0]         s_a_height,
    input  logic signed [15:0]  s_b_x,
    input  logic signed [15:0]  s_b_y,
    input  logic signed [15:0]  s_b_z,
    input  logic [14:0]         s_b_radius,
    input  logic [14:0]         s_b_height,
    output logic                m_valid,
    input  logic                m_ready,
    output logic                m_overlap,
    output logic [14:0]         m_distance,
    output logic signed [15:0]  m_depth,
    output logic signed [15:0]  m_delta_x,
    output logic signed [15:0]  m_delta_z,
    output logic signed [15:0]  m_push_x,
    output logic signed [15:0]  m_push_z
);

    localparam int QW = ccd_pkg::RADIUS_W + FRAC_BITS;
    localparam int PW = ccd_pkg::COORD_W + QW + 1;
    localparam int NC = ccd_pkg::SQRT_CELLS;

    logic adv;
    assign adv     = !m_valid || m_ready;
    assign s_ready = adv;

    // Stage 1: deltas, tops, radius sum
    logic               v1_reg;
    ccd_pkg::ctx_t      ctx1_reg;
    ccd_pkg::ctx_t      ctx1_next;
    logic signed [15:0] atop;
    logic signed [15:0] btop;

    always_comb begin
        atop = 16'(s_a_y + signed'({1'b0, s_a_height}));
        btop = 16'(s_b_y + signed'({1'b0, s_b_height}));
        ctx1_next.yrej = (atop < s_b_y) || (btop < s_a_y);
        ctx1_next.rsum = 16'({1'b0, s_a_radius} + {1'b0, s_b_radius});
        ctx1_next.dx   = 16'(s_b_x - s_a_x);
        ctx1_next.dz   = 16'(s_b_z - s_a_z);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            ctx1_reg <= ctx1_next;
        end
    end

    // Stage 2: squared XZ length
    logic               v2_reg;
    ccd_pkg::ctx_t      ctx2_reg;
    logic [31:0]        sq2_reg;
    logic signed [31:0] sqx;
    logic signed [31:0] sqz;

    assign sqx = ctx1_reg.dx * ctx1_reg.dx;
    assign sqz = ctx1_reg.dz * ctx1_reg.dz;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (adv) begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            ctx2_reg <= ctx1_reg;
            sq2_reg  <= unsigned'(sqx) + unsigned'(sqz);
        end
    end

    // Square root chain, two bits per cell
    ccd_pkg::sqrt_t sq_st [0:NC];
    logic           sq_v  [0:NC];

    always_comb begin
        sq_st[0].ctx  = ctx2_reg;
        sq_st[0].sq   = sq2_reg;
        sq_st[0].rem  = '0;
        sq_st[0].root = '0;
        sq_v[0]       = v2_reg;
    end

    for (genvar i = 0; i < NC; i++) begin : g_sqrt
        ccd_sqrt_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (adv),
            .in_valid  (sq_v[i]),
            .in_data   (sq_st[i]),
            .out_valid (sq_v[i+1]),
            .out_data  (sq_st[i+1])
        );
    end

    // Stage 3: saturated distance, depth, overlap
    logic               v3_reg;
    ccd_pkg::res_t      res3_reg;
    ccd_pkg::res_t      res3_next;

    always_comb begin
        res3_next.ctx = sq_st[NC].ctx;
        if (sq_st[NC].root > {1'b0, ccd_pkg::DIST_MAX}) begin
            res3_next.dlen = ccd_pkg::DIST_MAX;
        end else begin
            res3_next.dlen = sq_st[NC].root[14:0];
        end
        res3_next.depth = 16'(sq_st[NC].ctx.rsum - signed'({1'b0, res3_next.dlen}));
        res3_next.ov    = !(sq_st[NC].ctx.rsum < signed'({1'b0, res3_next.dlen}));
        res3_next.go    = res3_next.ov && (res3_next.dlen != '0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
        end else if (adv) begin
            v3_reg <= sq_v[NC];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            res3_reg <= res3_next;
        end
    end

    // Divider chain: (depth << FRAC_BITS) / distance, one bit per cell
    ccd_pkg::res_t      dv_res [0:QW];
    logic [QW-1:0]      dv_num [0:QW];
    logic [QW-1:0]      dv_quo [0:QW];
    logic [14:0]        dv_rem [0:QW];
    logic               dv_v   [0:QW];

    always_comb begin
        dv_res[0] = res3_reg;
        dv_num[0] = {res3_reg.depth[14:0], {FRAC_BITS{1'b0}}};
        dv_quo[0] = '0;
        dv_rem[0] = '0;
        dv_v[0]   = v3_reg;
    end

    for (genvar j = 0; j < QW; j++) begin : g_div
        ccd_div_cell #(.NW(QW)) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (adv),
            .in_valid  (dv_v[j]),
            .in_res    (dv_res[j]),
            .in_num    (dv_num[j]),
            .in_quo    (dv_quo[j]),
            .in_rem    (dv_rem[j]),
            .out_valid (dv_v[j+1]),
            .out_res   (dv_res[j+1]),
            .out_num   (dv_num[j+1]),
            .out_quo   (dv_quo[j+1]),
            .out_rem   (dv_rem[j+1])
        );
    end

    // Stage 4: delta times factor
    logic               v4_reg;
    ccd_pkg::res_t      res4_reg;
    logic signed [PW-1:0] px4_reg;
    logic signed [PW-1:0] pz4_reg;
    logic signed [QW:0]   fac;

    assign fac = dv_res[QW].go ? signed'({1'b0, dv_quo[QW]}) : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v4_reg <= 1'b0;
        end else if (adv) begin
            v4_reg <= dv_v[QW];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            res4_reg <= dv_res[QW];
            px4_reg  <= PW'(dv_res[QW].ctx.dx * fac);
            pz4_reg  <= PW'(dv_res[QW].ctx.dz * fac);
        end
    end

    // Stage 5: output register, floor shift and vertical reject
    logic               v5_reg;
    logic               ov_reg;
    logic [14:0]        dist_reg;
    logic signed [15:0] depth_reg;
    logic signed [15:0] dx_reg;
    logic signed [15:0] dz_reg;
    logic signed [15:0] px_reg;
    logic signed [15:0] pz_reg;
    logic               rej;

    assign rej = res4_reg.ctx.yrej;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v5_reg <= 1'b0;
        end else if (adv) begin
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            ov_reg    <= rej ? 1'b0 : res4_reg.ov;
            dist_reg  <= rej ? '0 : res4_reg.dlen;
            depth_reg <= rej ? '0 : res4_reg.depth;
            dx_reg    <= rej ? '0 : res4_reg.ctx.dx;
            dz_reg    <= rej ? '0 : res4_reg.ctx.dz;
            px_reg    <= rej ? '0 : px4_reg[FRAC_BITS +: 16];
            pz_reg    <= rej ? '0 : pz4_reg[FRAC_BITS +: 16];
        end
    end

    assign m_valid    = v5_reg;
    assign m_overlap  = ov_reg;
    assign m_distance = dist_reg;
    assign m_depth    = depth_reg;
    assign m_delta_x  = dx_reg;
    assign m_delta_z  = dz_reg;
    assign m_push_x   = px_reg;
    assign m_push_z   = pz_reg;

`ifndef ASSERT_OFF
    a_no_push_without_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_overlap |-> m_push_x == 16'sd0 && m_push_z == 16'sd0)
        else $error("push nonzero without overlap");
    a_no_push_at_zero_dist: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_distance == 15'd0 |-> m_push_x == 16'sd0 && m_push_z == 16'sd0)
        else $error("push nonzero at zero distance");
    a_depth_nonneg: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_overlap |-> !m_depth[15])
        else $error("negative depth with overlap");
    a_ready_rule: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready == (!m_valid || m_ready))
        else $error("input ready out of step with output stall");
`endif

endmodule

// ===== hdl/ccd_sqrt_cell.sv =====
// One digit cell of the pipelined integer square root.
`timescale 1ns / 1ps

module ccd_sqrt_cell (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            en,
    input  logic            in_valid,
    input  ccd_pkg::sqrt_t  in_data,
    output logic            out_valid,
    output ccd_pkg::sqrt_t  out_data
);

    logic           valid_reg;
    ccd_pkg::sqrt_t data_reg;
    ccd_pkg::sqrt_t data_next;
    logic [19:0]    rem2;
    logic [19:0]    trial;

    // Bring down two bits, try root*4+1
    always_comb begin
        rem2  = {in_data.rem, in_data.sq[ccd_pkg::SQ_W-1 -: 2]};
        trial = {2'b00, in_data.root, 2'b01};
        data_next     = in_data;
        data_next.sq  = {in_data.sq[ccd_pkg::SQ_W-3:0], 2'b00};
        if (rem2 >= trial) begin
            data_next.rem  = 18'(rem2 - trial);
            data_next.root = {in_data.root[ccd_pkg::ROOT_W-2:0], 1'b1};
        end else begin
            data_next.rem  = rem2[17:0];
            data_next.root = {in_data.root[ccd_pkg::ROOT_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// ===== hdl/ccd_div_cell.sv =====
// One quotient-bit cell of the pipelined restoring divider.
`timescale 1ns / 1ps

module ccd_div_cell #(
    parameter int NW = ccd_pkg::RADIUS_W + ccd_pkg::FRAC_BITS_D
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            en,
    input  logic                            in_valid,
    input  ccd_pkg::res_t                   in_res,
    input  logic [NW-1:0]                   in_num,
    input  logic [NW-1:0]                   in_quo,
    input  logic [ccd_pkg::RADIUS_W-1:0]    in_rem,
    output logic                            out_valid,
    output ccd_pkg::res_t                   out_res,
    output logic [NW-1:0]                   out_num,
    output logic [NW-1:0]                   out_quo,
    output logic [ccd_pkg::RADIUS_W-1:0]    out_rem
);

    logic                           valid_reg;
    ccd_pkg::res_t                  res_reg;
    logic [NW-1:0]                  num_reg;
    logic [NW-1:0]                  quo_reg;
    logic [ccd_pkg::RADIUS_W-1:0]   rem_reg;
    logic [ccd_pkg::RADIUS_W:0]     rem2;
    logic [ccd_pkg::RADIUS_W:0]     dvs;
    logic                           qbit;
    logic [ccd_pkg::RADIUS_W-1:0]   rem_next;

    // Shift in next numerator bit, subtract divisor if it fits
    always_comb begin
        rem2 = {in_rem, in_num[NW-1]};
        dvs  = {1'b0, in_res.dlen};
        qbit = (rem2 >= dvs);
        if (qbit) begin
            rem_next = ccd_pkg::RADIUS_W'(rem2 - dvs);
        end else begin
            rem_next = rem2[ccd_pkg::RADIUS_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            res_reg <= in_res;
            num_reg <= {in_num[NW-2:0], 1'b0};
            quo_reg <= {in_quo[NW-2:0], qbit};
            rem_reg <= rem_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_res   = res_reg;
    assign out_num   = num_reg;
    assign out_quo   = quo_reg;
    assign out_rem   = rem_reg;

endmodule

// ===== tb/tb_cylinder_collision_displacement.sv =====
// Self-checking testbench for the cylinder collision displacement pipe.
`timescale 1ns / 1ps

module tb_cylinder_collision_displacement;

    localparam int FRAC = ccd_pkg::FRAC_BITS_D;
    localparam int LATENCY = 21 + ccd_pkg::RADIUS_W + FRAC;
    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct packed {
        logic signed [15:0] ax, ay, az;
        logic [14:0]        ar, ah;
        logic signed [15:0] bx, by, bz;
        logic [14:0]        br, bh;
    } pair_t;

    typedef struct packed {
        logic               ov;
        logic [14:0]        dlen;
        logic signed [15:0] depth, dx, dz, px, pz;
    } hit_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic signed [15:0] s_a_x = '0, s_a_y = '0, s_a_z = '0;
    logic [14:0] s_a_radius = '0, s_a_height = '0;
    logic signed [15:0] s_b_x = '0, s_b_y = '0, s_b_z = '0;
    logic [14:0] s_b_radius = '0, s_b_height = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic m_overlap;
    logic [14:0] m_distance;
    logic signed [15:0] m_depth, m_delta_x, m_delta_z, m_push_x, m_push_z;

    hit_t hit_queue[$];
    int   errors = 0;
    int   idle_cycles = 0;
    int   stall_left = 0;
    bit   hold_off = 1'b0;

    always #5 aclk = ~aclk;

    cylinder_collision_displacement i_dut (.*);

    // Floor integer square root of a 32-bit value
    function automatic logic [31:0] floor_root(logic [31:0] v);
        logic [31:0] res, bitv;
        res = '0;
        bitv = 32'h4000_0000;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v = v - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // Expected collision result for one pair
    function automatic hit_t collide(pair_t p);
        hit_t h;
        logic signed [15:0] atop, btop, rsum, dx, dz, depth;
        logic [31:0] sq, root;
        logic [14:0] dlen;
        longint factor, prx, prz;
        h = '0;
        atop = p.ay + $signed({1'b0, p.ah});
        btop = p.by + $signed({1'b0, p.bh});
        if (atop < p.by || btop < p.ay) return h;
        rsum = {1'b0, p.ar} + {1'b0, p.br};
        dx = p.bx - p.ax;
        dz = p.bz - p.az;
        sq = 32'(int'(dx) * int'(dx)) + 32'(int'(dz) * int'(dz));
        root = floor_root(sq);
        dlen = (root > 32767) ? 15'h7fff : root[14:0];
        depth = rsum - $signed({1'b0, dlen});
        h.ov = !(int'(rsum) < int'(dlen));
        h.dlen = dlen;
        h.depth = depth;
        h.dx = dx;
        h.dz = dz;
        if (h.ov && dlen != 0) begin
            factor = (longint'(depth) <<< FRAC) / longint'(dlen);
            prx = (longint'(dx) * factor) >>> FRAC;
            prz = (longint'(dz) * factor) >>> FRAC;
            h.px = prx[15:0];
            h.pz = prz[15:0];
        end
        return h;
    endfunction

    // Offer one pair after the given gap; hold until accepted.
    // Valid stays high after the beat so back-to-back pairs need no toggle.
    task automatic send_pair(pair_t p, int gap);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        {s_a_x, s_a_y, s_a_z, s_a_radius, s_a_height,
         s_b_x, s_b_y, s_b_z, s_b_radius, s_b_height} <= p;
        hit_queue.push_back(collide(p));
        do @(posedge aclk); while (!s_ready);
    endtask

    function automatic int rand_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic pair_t rand_pair();
        pair_t p;
        int mode;
        p = pair_t'({$urandom, $urandom, $urandom, $urandom, $urandom});
        mode = $urandom_range(0, 9);
        if (mode < 7) begin
            // Nearby cylinders so that most pairs touch
            p.bx = p.ax + $signed(16'($urandom_range(0, 4000)) - 16'd2000);
            p.bz = p.az + $signed(16'($urandom_range(0, 4000)) - 16'd2000);
            p.by = p.ay + $signed(16'($urandom_range(0, 2000)) - 16'd1000);
            p.ar = 15'($urandom_range(0, 2000));
            p.br = 15'($urandom_range(0, 2000));
            p.ah = 15'($urandom_range(0, 2000));
            p.bh = 15'($urandom_range(0, 2000));
            if (mode == 6) p.bx = p.ax;
        end
        return p;
    endfunction

    // Result side: random stalls, occasional long ones, plus the long hold-off
    always @(posedge aclk) begin
        if (!aresetn || hold_off) begin
            m_ready <= 1'b0;
        end else if (stall_left > 0) begin
            m_ready <= 1'b0;
            stall_left <= stall_left - 1;
        end else if ($urandom_range(0, 99) < 70) begin
            m_ready <= 1'b1;
        end else if ($urandom_range(0, 99) < 3) begin
            m_ready <= 1'b0;
            stall_left <= $urandom_range(10, 40);
        end else begin
            m_ready <= ($urandom_range(0, 3) != 0) ? 1'b1 : 1'b0;
        end
    end

    // Compare each result beat with the oldest expectation
    always @(posedge aclk) begin
        hit_t e;
        if (aresetn && m_valid && m_ready) begin
            if (hit_queue.size() == 0) begin
                $error("unexpected result beat");
                errors++;
            end else begin
                e = hit_queue.pop_front();
                if (m_overlap !== e.ov) begin
                    $error("overlap exp %0d got %0d", e.ov, m_overlap); errors++;
                end
                if (m_distance !== e.dlen) begin
                    $error("distance exp %0d got %0d", e.dlen, m_distance); errors++;
                end
                if (m_depth !== e.depth) begin
                    $error("depth exp %0d got %0d", e.depth, m_depth); errors++;
                end
                if (m_delta_x !== e.dx) begin
                    $error("delta_x exp %0d got %0d", e.dx, m_delta_x); errors++;
                end
                if (m_delta_z !== e.dz) begin
                    $error("delta_z exp %0d got %0d", e.dz, m_delta_z); errors++;
                end
                if (m_push_x !== e.px) begin
                    $error("push_x exp %0d got %0d", e.px, m_push_x); errors++;
                end
                if (m_push_z !== e.pz) begin
                    $error("push_z exp %0d got %0d", e.pz, m_push_z); errors++;
                end
            end
        end
    end

    // Watchdog on cycles with no beat on either side
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || hold_off) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    function automatic pair_t mk(int ax, int ay, int az, int ar, int ah,
                                 int bx, int by, int bz, int br, int bh);
        pair_t p;
        p.ax = 16'(ax); p.ay = 16'(ay); p.az = 16'(az);
        p.ar = 15'(ar); p.ah = 15'(ah);
        p.bx = 16'(bx); p.by = 16'(by); p.bz = 16'(bz);
        p.br = 15'(br); p.bh = 15'(bh);
        return p;
    endfunction

    // Directed corners: rejects, wraps, saturation, zero distance
    task automatic test_directed();
        send_pair(mk(0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0);
        send_pair(mk(0, 0, 0, 10, 5, 3, 6, 4, 10, 5), 0);
        send_pair(mk(0, 10, 0, 10, 5, 3, 0, 4, 10, 5), 1);
        send_pair(mk(0, 0, 0, 10, 5, 30, 0, 40, 10, 5), 0);
        send_pair(mk(5, 0, 5, 100, 5, 5, 0, 5, 100, 5), 0);
        send_pair(mk(0, 0, 0, 32767, 10, 10, 0, 0, 32767, 10), 0);
        send_pair(mk(-32768, 0, -32768, 32767, 10, 32767, 0, 32767, 32767, 10), 2);
        send_pair(mk(32767, 0, 32767, 0, 10, -32768, 0, -32768, 0, 10), 0);
        send_pair(mk(0, 32767, 0, 50, 32767, 20, 32000, 0, 50, 32767), 0);
        send_pair(mk(0, -32768, 0, 50, 32767, 20, -32768, 0, 50, 0), 0);
        send_pair(mk(0, 32000, 0, 50, 1000, 20, -32768, 0, 50, 0), 0);
        send_pair(mk(-100, 0, 200, 300, 9, 100, 3, -200, 300, 9), 0);
        send_pair(mk(1000, 0, 1000, 32767, 0, -1000, 0, -1000, 1, 0), 0);
        send_pair(mk(0, 0, 0, 20000, 0, 30000, 0, 0, 20000, 0), 0);
        send_pair(mk(-1, -1, -1, 1, 1, 0, 0, 0, 1, 1), 0);
    endtask

    task automatic test_random(int n);
        repeat (n) send_pair(rand_pair(), rand_gap());
    endtask

    task automatic test_back_pressure();
        fork
            begin
                hold_off = 1'b1;
                repeat (200) @(posedge aclk);
                hold_off = 1'b0;
            end
            repeat (120) send_pair(rand_pair(), 0);
        join
    endtask

    task automatic test_burst();
        repeat (200) send_pair(rand_pair(), 0);
    endtask

    initial begin
        int drain;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_random(700);
        test_back_pressure();
        test_burst();
        test_random(800);
        s_valid <= 1'b0;
        drain = 0;
        while (hit_queue.size() != 0 && drain < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            drain++;
        end
        repeat (LATENCY + 10) @(posedge aclk);
        if (errors == 0 && hit_queue.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
